### src/gne_pkg.sv
// ----------------------------------------------------------------------------
// Grid neighbour expansion package
// Shared types, constants and small helpers for the neighbour expansion core.
// ----------------------------------------------------------------------------
package gne_pkg;

  // Default grid size.
  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 32;

  // Field widths.
  localparam int COORD_W     = 5;
  localparam int COST_W      = 9;
  localparam int PRED_W      = 10;
  localparam int POS_W       = 6;   // coordinate with one spare bit for the edge
  localparam int COST_SUM_W  = 10;
  localparam int CFG_INDEX_W = 1;
  localparam int STEP_W      = 4;

  // Step costs of the octile distance and the saturation value.
  localparam logic [COST_SUM_W-1:0] DIAG_COST     = 10'd14;
  localparam logic [COST_SUM_W-1:0] STRAIGHT_COST = 10'd10;
  localparam logic [COST_W-1:0]     COST_MAX      = 9'd511;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] REG_GOAL_X = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GOAL_Y = 1'd1;
  localparam logic [COORD_W-1:0]     GOAL_X_RESET = 5'd10;
  localparam logic [COORD_W-1:0]     GOAL_Y_RESET = 5'd8;

  // Offset codes: a step of minus one, none, or plus one.
  localparam logic [1:0] OFS_NEG  = 2'd0;
  localparam logic [1:0] OFS_ZERO = 2'd1;
  localparam logic [1:0] OFS_POS  = 2'd2;

  // Scan steps: the centre first, then the eight neighbours.
  localparam logic [STEP_W-1:0] STEP_CENTRE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;

  // Input word: the cell to expand.
  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } cell_t;

  // Output word: one neighbour report.
  typedef struct packed {
    logic [COORD_W-1:0] nbr_x;
    logic [COORD_W-1:0] nbr_y;
    logic [COST_W-1:0]  heuristic_cost;
    logic               updated;
    logic               last;
  } result_t;

  // Goal position from the configuration registers.
  typedef struct packed {
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
  } goal_t;

  // One grid memory entry.
  typedef struct packed {
    logic              expanded;
    logic              cost_valid;
    logic [COST_W-1:0] cost;
    logic [PRED_W-1:0] pred;
  } entry_t;

  // Column offset code of a scan step (dx outer loop).
  function automatic logic [1:0] nbr_dx(input logic [STEP_W-1:0] step);
    logic [1:0] code;
    code = OFS_ZERO;
    unique case (step) inside
      4'd1, 4'd2, 4'd3: code = OFS_NEG;
      4'd4, 4'd5:       code = OFS_ZERO;
      4'd6, 4'd7, 4'd8: code = OFS_POS;
      default:          code = OFS_ZERO;
    endcase
    return code;
  endfunction

  // Row offset code of a scan step (dy inner loop).
  function automatic logic [1:0] nbr_dy(input logic [STEP_W-1:0] step);
    logic [1:0] code;
    code = OFS_ZERO;
    unique case (step) inside
      4'd1, 4'd4, 4'd6: code = OFS_NEG;
      4'd2, 4'd7:       code = OFS_ZERO;
      4'd3, 4'd5, 4'd8: code = OFS_POS;
      default:          code = OFS_ZERO;
    endcase
    return code;
  endfunction

  // Applies an offset code; stepping left of zero gives all ones.
  function automatic logic [POS_W-1:0] shift_coord(input logic [COORD_W-1:0] c,
                                                   input logic [1:0] code);
    return {1'b0, c} + {4'b0, code} - 6'd1;
  endfunction

endpackage

### src/gne_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module gne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while the enable is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/gne_cost.sv
// ----------------------------------------------------------------------------
// Octile distance unit
// Distance from a grid position to the goal: 14 per diagonal, 10 per straight.
// ----------------------------------------------------------------------------
module gne_cost (
  input  gne_pkg::goal_t                goal,
  input  logic [gne_pkg::POS_W-1:0]     pos_x,
  input  logic [gne_pkg::POS_W-1:0]     pos_y,
  output logic [gne_pkg::COST_W-1:0]    cost
);

  logic [gne_pkg::POS_W-1:0]      goal_x6;
  logic [gne_pkg::POS_W-1:0]      goal_y6;
  logic [gne_pkg::POS_W-1:0]      dist_x;
  logic [gne_pkg::POS_W-1:0]      dist_y;
  logic [gne_pkg::POS_W-1:0]      diag;
  logic [gne_pkg::POS_W-1:0]      straight;
  logic [gne_pkg::COST_SUM_W-1:0] sum;

  // Absolute distances along each axis.
  assign goal_x6 = {1'b0, goal.goal_x};
  assign goal_y6 = {1'b0, goal.goal_y};
  assign dist_x  = (pos_x > goal_x6) ? (pos_x - goal_x6) : (goal_x6 - pos_x);
  assign dist_y  = (pos_y > goal_y6) ? (pos_y - goal_y6) : (goal_y6 - pos_y);

  // Diagonal steps cover the shorter axis, straight steps the remainder.
  assign diag     = (dist_x < dist_y) ? dist_x : dist_y;
  assign straight = (dist_x < dist_y) ? (dist_y - dist_x) : (dist_x - dist_y);

  // Weighted sum, saturated to the field width.
  assign sum  = 10'(diag) * gne_pkg::DIAG_COST + 10'(straight) * gne_pkg::STRAIGHT_COST;
  assign cost = (sum > {1'b0, gne_pkg::COST_MAX}) ? gne_pkg::COST_MAX : sum[8:0];

endmodule

### src/grid_neighbor_expansion_core.sv
// ----------------------------------------------------------------------------
// Grid neighbour expansion core
// Expands one grid cell of a path search: marks it expanded and reports each
// on-grid neighbour not yet expanded, giving it an octile cost to the goal.
//
//   Channel  Direction  Handshake                    Word
//   cell     in         cell_valid / cell_stall      gne_pkg::cell_t
//   result   out        result_valid / result_stall  gne_pkg::result_t
//   cfg      in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// An expanded cell passes the accept, which reads the centre, a scan step for
// the centre and a scan step per neighbour with the grid memory read one step
// ahead, and a closing step for the final report. A cell that is off the grid
// or already expanded ends after the centre step. After reset a clearing pass
// writes every entry once, GRID_WIDTH * GRID_HEIGHT entries (1024 by default);
// cells are stalled then. A stalled result holds the scan only when another
// result must be sent.
// ----------------------------------------------------------------------------
module grid_neighbor_expansion_core #(
  parameter int GRID_WIDTH  = gne_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gne_pkg::GRID_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cell_valid,
  output logic                              cell_stall,
  input  gne_pkg::cell_t                    cell_word,
  output logic                              result_valid,
  input  logic                              result_stall,
  output gne_pkg::result_t                  result_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gne_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gne_pkg::COORD_W-1:0]       cfg_data
);

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0]    GRID_W9  = 9'(GRID_WIDTH);
  localparam logic [8:0]    GRID_H9  = 9'(GRID_HEIGHT);
  localparam logic [AW-1:0] ADDR_TOP = AW'(DEPTH - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FIN} state_t;

  // True where a position lies on the grid.
  function automatic logic on_grid(input logic [gne_pkg::POS_W-1:0] px,
                                   input logic [gne_pkg::POS_W-1:0] py);
    return (px != 6'h3F) && (py != 6'h3F) &&
           ({3'b0, px} < GRID_W9) && ({3'b0, py} < GRID_H9);
  endfunction

  // Row-major memory address of a position.
  function automatic logic [AW-1:0] cell_index(input logic [gne_pkg::POS_W-1:0] px,
                                               input logic [gne_pkg::POS_W-1:0] py);
    logic [16:0] lin;
    lin = 17'(py) * 17'(GRID_WIDTH) + 17'(px);
    return lin[AW-1:0];
  endfunction

  state_t                          state;
  logic [AW-1:0]                   clr_addr;
  logic [gne_pkg::STEP_W-1:0]      step;
  logic [gne_pkg::COORD_W-1:0]     cx;
  logic [gne_pkg::COORD_W-1:0]     cy;
  logic                            off;
  logic                            pend_valid;
  logic [gne_pkg::COORD_W-1:0]     pend_x;
  logic [gne_pkg::COORD_W-1:0]     pend_y;
  logic [gne_pkg::COST_W-1:0]      pend_cost;
  gne_pkg::goal_t                  goal;

  logic                            cell_take;
  logic                            slot_free;
  logic                            advance;
  logic                            push;
  gne_pkg::result_t                push_word;
  gne_pkg::result_t                empty_word;
  logic [gne_pkg::STEP_W-1:0]      step_inc;
  logic [gne_pkg::POS_W-1:0]       acc_x6;
  logic [gne_pkg::POS_W-1:0]       acc_y6;
  logic [gne_pkg::POS_W-1:0]       cur_x6;
  logic [gne_pkg::POS_W-1:0]       cur_y6;
  logic [gne_pkg::POS_W-1:0]       nxt_x6;
  logic [gne_pkg::POS_W-1:0]       nxt_y6;
  logic                            cur_on;
  logic                            nxt_on;
  logic                            nbr_upd;
  logic [gne_pkg::COST_W-1:0]      oct_cost;
  logic [gne_pkg::COST_W-1:0]      upd_cost;

  logic                            ram_we;
  logic [AW-1:0]                   ram_wa;
  gne_pkg::entry_t                 ram_wd;
  logic                            ram_re;
  logic [AW-1:0]                   ram_ra;
  gne_pkg::entry_t                 ram_rd;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal.goal_x <= gne_pkg::GOAL_X_RESET;
      goal.goal_y <= gne_pkg::GOAL_Y_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gne_pkg::REG_GOAL_X: goal.goal_x <= cfg_data;
        gne_pkg::REG_GOAL_Y: goal.goal_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid memory: expanded flag, cost, cost valid flag and predecessor per cell.
  gne_ram #(
    .WIDTH ($bits(gne_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // Heuristic of the neighbour being processed.
  gne_cost u_cost (
    .goal  (goal),
    .pos_x (cur_x6),
    .pos_y (cur_y6),
    .cost  (oct_cost)
  );

  // Positions: the incoming cell, the current step and the step read ahead.
  assign acc_x6   = {1'b0, cell_word.cell_x};
  assign acc_y6   = {1'b0, cell_word.cell_y};
  assign step_inc = step + 4'd1;
  assign cur_x6   = gne_pkg::shift_coord(cx, gne_pkg::nbr_dx(step));
  assign cur_y6   = gne_pkg::shift_coord(cy, gne_pkg::nbr_dy(step));
  assign nxt_x6   = gne_pkg::shift_coord(cx, gne_pkg::nbr_dx(step_inc));
  assign nxt_y6   = gne_pkg::shift_coord(cy, gne_pkg::nbr_dy(step_inc));
  assign cur_on   = on_grid(cur_x6, cur_y6);
  assign nxt_on   = on_grid(nxt_x6, nxt_y6);

  // A neighbour is updated when on the grid and not yet expanded.
  assign nbr_upd  = cur_on && !ram_rd.expanded;
  assign upd_cost = ram_rd.cost_valid ? ram_rd.cost : oct_cost;

  assign cell_stall = (state != S_IDLE);
  assign cell_take  = cell_valid && !cell_stall;
  assign slot_free  = !result_valid || !result_stall;

  always_comb begin
    empty_word      = '0;
    empty_word.last = 1'b1;
  end

  // Scan control: what to send, write and read in this cycle.
  always_comb begin
    push      = 1'b0;
    push_word = empty_word;
    advance   = 1'b0;
    ram_we    = 1'b0;
    ram_wa    = '0;
    ram_wd    = '0;
    ram_re    = 1'b0;
    ram_ra    = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_addr;
      end
      S_IDLE: begin
        ram_re = cell_take && on_grid(acc_x6, acc_y6);
        ram_ra = cell_index(acc_x6, acc_y6);
      end
      S_SCAN: begin
        if (step == gne_pkg::STEP_CENTRE) begin
          // Centre: report empty if off the grid or done, otherwise mark it.
          push    = off || ram_rd.expanded;
          advance = !push || slot_free;
          push    = push && advance;
          if (advance && !off && !ram_rd.expanded) begin
            ram_we          = 1'b1;
            ram_wa          = cell_index({1'b0, cx}, {1'b0, cy});
            ram_wd          = ram_rd;
            ram_wd.expanded = 1'b1;
          end
        end else begin
          // Neighbour: if on the grid and not yet expanded, update it and send the previously held report.
          push    = nbr_upd && pend_valid;
          advance = !push || slot_free;
          push    = push && advance;
          push_word.nbr_x          = pend_x;
          push_word.nbr_y          = pend_y;
          push_word.heuristic_cost = pend_cost;
          push_word.updated        = 1'b1;
          push_word.last           = 1'b0;
          if (advance && nbr_upd) begin
            ram_we            = 1'b1;
            ram_wa            = cell_index(cur_x6, cur_y6);
            ram_wd.expanded   = 1'b0;
            ram_wd.cost_valid = 1'b1;
            ram_wd.cost       = upd_cost;
            ram_wd.pred       = {cy, cx};
          end
        end
        if (step != gne_pkg::STEP_LAST && !(step == gne_pkg::STEP_CENTRE &&
            (off || ram_rd.expanded))) begin
          ram_re = advance && nxt_on;
          ram_ra = cell_index(nxt_x6, nxt_y6);
        end
      end
      S_FIN: begin
        // Closing report: the held neighbour, or empty if none was updated.
        push    = slot_free;
        advance = slot_free;
        if (pend_valid) begin
          push_word.nbr_x          = pend_x;
          push_word.nbr_y          = pend_y;
          push_word.heuristic_cost = pend_cost;
          push_word.updated        = 1'b1;
          push_word.last           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer state, held report and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      step         <= gne_pkg::STEP_CENTRE;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (push) begin
        result_valid <= 1'b1;
        result_word  <= push_word;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_TOP) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cell_take) begin
            cx         <= cell_word.cell_x;
            cy         <= cell_word.cell_y;
            off        <= !on_grid(acc_x6, acc_y6);
            step       <= gne_pkg::STEP_CENTRE;
            pend_valid <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (advance) begin
            if (step == gne_pkg::STEP_CENTRE && (off || ram_rd.expanded)) begin
              state <= S_IDLE;
            end else begin
              if (step != gne_pkg::STEP_CENTRE && nbr_upd) begin
                pend_valid <= 1'b1;
                pend_x     <= cur_x6[gne_pkg::COORD_W-1:0];
                pend_y     <= cur_y6[gne_pkg::COORD_W-1:0];
                pend_cost  <= upd_cost;
              end
              if (step == gne_pkg::STEP_LAST) begin
                state <= S_FIN;
              end else begin
                step <= step_inc;
              end
            end
          end
        end
        S_FIN: begin
          if (advance) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // No cell is taken until the clearing pass has finished.
  assert property (@(posedge clk) rst |=> cell_stall)
    else $error("cell taken during the clearing pass");

  // A read never targets the entry written in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_wa != ram_ra))
    else $error("grid memory read and write collide");

  // An empty report always closes its cell.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_word.updated) |-> result_word.last)
    else $error("empty report without last");

  // No report is held over between cells.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held report left over after a cell");
`endif

endmodule

### test/grid_neighbor_expansion_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid neighbour expansion core testbench
// Sends cells to expand and checks every neighbour report against an
// expansion model of the grid held in a small scoreboard. A short directed
// part covers the corners, edges, cells already expanded, the goal cell and
// a cell hemmed in by expanded neighbours. Random phases under three goal
// settings follow, mostly walks through neighbouring cells, with idling on
// either side and one long hold-off of the result channel.
// ----------------------------------------------------------------------------
import gne_pkg::*;

// Expansion model of the grid and the queue of reports it predicts.
class expansion_scoreboard;
  localparam int GRID_W = GRID_WIDTH_DEF;
  localparam int GRID_H = GRID_HEIGHT_DEF;

  bit                 expanded[GRID_W*GRID_H];
  bit                 cost_known[GRID_W*GRID_H];
  logic [COST_W-1:0]  cost[GRID_W*GRID_H];
  logic [COORD_W-1:0] goal_x;
  logic [COORD_W-1:0] goal_y;
  result_t            expected_reports[$];
  int                 errors;

  function new();
    foreach (expanded[k]) begin
      expanded[k]   = 1'b0;
      cost_known[k] = 1'b0;
      cost[k]       = '0;
    end
    goal_x = GOAL_X_RESET;
    goal_y = GOAL_Y_RESET;
    errors = 0;
  endfunction

  function void set_goal(logic [CFG_INDEX_W-1:0] idx, logic [COORD_W-1:0] value);
    if (idx == REG_GOAL_X) begin
      goal_x = value;
    end else begin
      goal_y = value;
    end
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  // Octile distance to the goal, saturated to the cost width.
  function logic [COST_W-1:0] octile_cost(int x, int y);
    int dx, dy, diag, straight, sum;
    dx = (x > goal_x) ? x - goal_x : goal_x - x;
    dy = (y > goal_y) ? y - goal_y : goal_y - y;
    diag = (dx < dy) ? dx : dy;
    straight = (dx < dy) ? dy - dx : dx - dy;
    sum = diag * 14 + straight * 10;
    return (sum > 511) ? COST_MAX : COST_W'(sum);
  endfunction

  // Expands an accepted cell and queues the reports it should cause.
  function void expand_cell(cell_t c);
    int      cx, cy, nx, ny, idx, n;
    bit      open;
    result_t r;
    cx = c.cell_x;
    cy = c.cell_y;
    n = 0;
    open = (cx < GRID_W) && (cy < GRID_H);
    if (open) begin
      open = !expanded[cy*GRID_W + cx];
    end
    if (open) begin
      expanded[cy*GRID_W + cx] = 1'b1;
      // Column offset outer, row offset inner, centre skipped.
      for (int i = -1; i <= 1; i++) begin
        for (int j = -1; j <= 1; j++) begin
          nx = cx + i;
          ny = cy + j;
          if ((i != 0 || j != 0) && nx >= 0 && nx < GRID_W && ny >= 0 && ny < GRID_H) begin
            idx = ny*GRID_W + nx;
            if (!expanded[idx]) begin
              if (!cost_known[idx]) begin
                cost[idx] = octile_cost(nx, ny);
                cost_known[idx] = 1'b1;
              end
              r = '0;
              r.nbr_x = COORD_W'(nx);
              r.nbr_y = COORD_W'(ny);
              r.heuristic_cost = cost[idx];
              r.updated = 1'b1;
              expected_reports.push_back(r);
              n++;
            end
          end
        end
      end
    end
    // Every cell ends with a word marked last; an empty report when nothing moved.
    if (n == 0) begin
      r = '0;
      r.last = 1'b1;
      expected_reports.push_back(r);
    end else begin
      expected_reports[expected_reports.size()-1].last = 1'b1;
    end
  endfunction

  function void compare_field(string name, logic [COST_W-1:0] want, logic [COST_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compares one accepted report with the oldest prediction.
  function void check_report(result_t r);
    result_t want;
    if (expected_reports.size() == 0) begin
      $error("report word with no prediction waiting: %h", r);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    compare_field("nbr_x", want.nbr_x, r.nbr_x);
    compare_field("nbr_y", want.nbr_y, r.nbr_y);
    compare_field("heuristic_cost", want.heuristic_cost, r.heuristic_cost);
    compare_field("updated", want.updated, r.updated);
    compare_field("last", want.last, r.last);
  endfunction
endclass

module grid_neighbor_expansion_core_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cell_valid = 1'b0;
  logic                   cell_stall;
  cell_t                  cell_word = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result_word;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_GOAL_X;
  logic [COORD_W-1:0]     cfg_data = '0;

  expansion_scoreboard grid_sb = new();
  cell_t               sent_cells[$];
  int                  tx_gap_pct = 0;
  int                  rx_hold_pct = 0;
  int                  long_hold_len = 0;
  int                  long_hold_count = 0;
  int                  cycle_count = 0;

  grid_neighbor_expansion_core dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_word    (cell_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: one long hold-off when asked, otherwise random stalls.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (long_hold_count < long_hold_len) begin
      result_stall <= 1'b1;
      long_hold_count <= long_hold_count + 1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < rx_hold_pct);
    end
  end

  // Checks each report word as it is taken.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      grid_sb.check_report(result_word);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one cell after a random gap and waits until it is taken.
  task automatic send_cell(cell_t c);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_word <= c;
    do @(posedge clk); while (cell_stall);
    grid_sb.expand_cell(c);
    sent_cells.push_back(c);
  endtask

  task automatic send_at(int x, int y);
    cell_t c;
    c.cell_x = COORD_W'(x);
    c.cell_y = COORD_W'(y);
    send_cell(c);
  endtask

  // One register write, with the channel dropped back to idle after it.
  task automatic write_goal(logic [CFG_INDEX_W-1:0] idx, logic [COORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    grid_sb.set_goal(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly short walks from recent cells, some repeats, some jumps anywhere.
  function automatic cell_t pick_cell();
    cell_t c;
    cell_t base;
    int    roll, lo, x, y;
    roll = $urandom_range(0, 99);
    if (sent_cells.size() == 0 || roll < 25) begin
      c.cell_x = COORD_W'($urandom_range(0, 31));
      c.cell_y = COORD_W'($urandom_range(0, 31));
    end else begin
      lo = (sent_cells.size() > 8) ? sent_cells.size() - 8 : 0;
      base = sent_cells[$urandom_range(lo, sent_cells.size() - 1)];
      if (roll < 35) begin
        c = base;
      end else begin
        x = int'(base.cell_x) + int'($urandom_range(0, 2)) - 1;
        y = int'(base.cell_y) + int'($urandom_range(0, 2)) - 1;
        x = (x < 0) ? 0 : (x > 31) ? 31 : x;
        y = (y < 0) ? 0 : (y > 31) ? 31 : y;
        c.cell_x = COORD_W'(x);
        c.cell_y = COORD_W'(y);
      end
    end
    return c;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_cell(pick_cell());
  endtask

  // Lets every predicted word arrive, then allows the scan to settle.
  task automatic finish_phase();
    cell_valid <= 1'b0;
    @(posedge clk);
    while (grid_sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset goal; the sender idles little, the receiver much.
    tx_gap_pct = 8;
    rx_hold_pct = 49;
    send_at(31, 31);
    send_at(0, 31);
    send_at(31, 0);
    send_at(31, 31);
    send_at(30, 30);
    send_at(0, 15);
    send_at(15, 0);
    // The cell below the goal reports the goal itself at zero cost.
    send_at(10, 9);
    send_at(10, 8);
    // Ring of expanded cells, then the centre has nothing left to report.
    for (int x = 20; x <= 22; x++) begin
      for (int y = 20; y <= 22; y++) begin
        if (x != 21 || y != 21) begin
          send_at(x, y);
        end
      end
    end
    send_at(21, 21);
    finish_phase();

    // Far corner goal: the origin reaches the largest cost.
    write_goal(REG_GOAL_X, 5'd31);
    write_goal(REG_GOAL_Y, 5'd31);
    tx_gap_pct = 8;
    rx_hold_pct = 49;
    send_at(1, 1);
    send_at(0, 0);
    run_random(120);
    finish_phase();

    write_goal(REG_GOAL_X, 5'd0);
    write_goal(REG_GOAL_Y, 5'd0);
    tx_gap_pct = 49;
    rx_hold_pct = 8;
    run_random(120);
    finish_phase();

    // Random goal, no idling, and one long hold-off to back the block up.
    write_goal(REG_GOAL_Y, COORD_W'($urandom_range(0, 31)));
    write_goal(REG_GOAL_X, COORD_W'($urandom_range(0, 31)));
    tx_gap_pct = 0;
    rx_hold_pct = 0;
    long_hold_len = 300;
    run_random(115);
    finish_phase();

    repeat (20) @(posedge clk);
    if (grid_sb.errors == 0 && grid_sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
src/gne_pkg.sv
src/gne_ram.sv
src/gne_cost.sv
src/grid_neighbor_expansion_core.sv
test/grid_neighbor_expansion_core_tb.sv
